FILE: design/assert_macros.svh
// Assertion helpers used by the RTL. With SYNTH defined they expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ATB_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ATB_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ATB_ASSERT(label, clk, rst, prop, msg)
`define ATB_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

FILE: design/atb_pkg.sv
`default_nettype none

package atb_pkg;

   localparam int unsigned LBA28_W     = 28;
   localparam int unsigned CHS_RECIP_W = 29;
   localparam int unsigned CHS_QUOT_W  = 22;
   // ceil(2^34 / 63): exact quotient by 63 for every 28-bit address.
   localparam int unsigned CHS_RECIP_SHIFT = 34;
   localparam logic [CHS_RECIP_W-1:0] CHS_RECIP = 29'h10410411;

   localparam logic [7:0] DEVSEL_CHS   = 8'hA0;
   localparam logic [7:0] DEVSEL_LBA   = 8'hE0;
   localparam logic [7:0] OP_READ      = 8'h20;
   localparam logic [7:0] OP_READ_EXT  = 8'h24;
   localparam logic [7:0] OP_WRITE     = 8'h30;
   localparam logic [7:0] OP_WRITE_EXT = 8'h34;
   localparam logic [7:0] OP_FLUSH     = 8'hE7;
   localparam logic [7:0] OP_FLUSH_EXT = 8'hEA;

   localparam int unsigned CSR_ADDR_W = 5;

   typedef enum logic [2:0] {
      REG_PRESENT  = 3'd0,
      REG_LBA_CAP  = 3'd1,
      REG_CAP0     = 3'd2,
      REG_CAP1     = 3'd3,
      REG_CAP2     = 3'd4,
      REG_CAP3     = 3'd5
   } reg_index_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_ABSENT = 2'd1,
      STATUS_RANGE  = 2'd2
   } status_type;

   typedef enum logic {
      DIR_READ  = 1'b0,
      DIR_WRITE = 1'b1
   } dir_type;

   typedef struct packed {
      logic        req_type;
      logic [1:0]  drive_num;
      logic [31:0] block_addr;
      logic [7:0]  sector_count;
   } req_payload_type;

   typedef struct packed {
      status_type  status;
      logic        channel_sel;
      logic [7:0]  device_select;
      logic        use_lba48;
      logic [7:0]  addr_byte0;
      logic [7:0]  addr_byte1;
      logic [7:0]  addr_byte2;
      logic [7:0]  addr_byte3;
      logic [7:0]  count_out;
      logic [7:0]  command_code;
      logic [7:0]  flush_code;
   } rsp_payload_type;

   typedef struct packed {
      logic [3:0]        present_mask;
      logic [3:0]        lba_capable_mask;
      logic [3:0][31:0]  capacity;
   } cfg_type;

endpackage

`default_nettype wire

FILE: design/atb_if.sv
`default_nettype none

interface atb_req_if;
   logic                      valid;
   logic                      ready;
   atb_pkg::req_payload_type  data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface atb_rsp_if;
   logic                      valid;
   logic                      ready;
   atb_pkg::rsp_payload_type  data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: design/ata_taskfile_command_builder.sv
// ATA taskfile command builder.
// A request item (direction, drive 0-3, 32-bit LBA, sector count) enters on the
// req channel; one result item with the taskfile register values leaves on the
// rsp channel for each request. Both channels use valid/ready handshakes.
// An accepted request item waits in the input register, then its translation lands
// in the result register, where the receiver can take it. Throughput is one item
// per cycle while the receiver does not stall, since both registers then advance
// each cycle and the translation is a single combinational pass between them.
// When the receiver stalls, the result register holds its item and the input
// register still takes one more request; ready drops only when both are full.
// Drive presence, LBA support and capacities come from the csr port, an APB-style slave
// with six registers at byte addresses 0, 4, ... 20; the user is to write it only while
// no request is in flight, which the block does not enforce. Reset empties both registers
// and clears all configuration to zero, so every request then reports the drive as absent.
`default_nettype none
`include "assert_macros.svh"

module ata_taskfile_command_builder (
   input  wire                              clock,
   input  wire                              reset,
   atb_req_if.sink                          req,
   atb_rsp_if.source                        rsp,
   input  wire                              csr_psel,
   input  wire                              csr_penable,
   input  wire                              csr_pwrite,
   input  wire [atb_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire [31:0]                       csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);

   logic                      in_valid_ff, in_valid_in;
   atb_pkg::req_payload_type  in_req_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   atb_pkg::rsp_payload_type  rsp_data_ff, rsp_data_in;
   atb_pkg::cfg_type          cfg_ff, cfg_in;
   logic                      out_free;
   logic                      req_accept;
   logic                      csr_write;
   atb_pkg::reg_index_type    csr_index;

   // Pipeline control
   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign req.ready  = !in_valid_ff || out_free;
   assign req_accept = req.valid && req.ready;

   assign in_valid_in  = (in_valid_ff && !out_free) || req_accept;
   assign rsp_valid_in = (rsp_valid_ff && !rsp.ready) || (in_valid_ff && out_free);

   atb_xlate u_xlate (
      .req_item (in_req_ff),
      .cfg      (cfg_ff),
      .rsp_item (rsp_data_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_req_ff <= req.data;
      end
      if (in_valid_ff && out_free) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_data_ff;

   // Configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = atb_pkg::reg_index_type'(csr_paddr[atb_pkg::CSR_ADDR_W-1:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            atb_pkg::REG_PRESENT: cfg_in.present_mask     = csr_pwdata[3:0];
            atb_pkg::REG_LBA_CAP: cfg_in.lba_capable_mask = csr_pwdata[3:0];
            atb_pkg::REG_CAP0:    cfg_in.capacity[0]      = csr_pwdata;
            atb_pkg::REG_CAP1:    cfg_in.capacity[1]      = csr_pwdata;
            atb_pkg::REG_CAP2:    cfg_in.capacity[2]      = csr_pwdata;
            atb_pkg::REG_CAP3:    cfg_in.capacity[3]      = csr_pwdata;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (csr_index)
         atb_pkg::REG_PRESENT: csr_prdata = {28'd0, cfg_ff.present_mask};
         atb_pkg::REG_LBA_CAP: csr_prdata = {28'd0, cfg_ff.lba_capable_mask};
         atb_pkg::REG_CAP0:    csr_prdata = cfg_ff.capacity[0];
         atb_pkg::REG_CAP1:    csr_prdata = cfg_ff.capacity[1];
         atb_pkg::REG_CAP2:    csr_prdata = cfg_ff.capacity[2];
         atb_pkg::REG_CAP3:    csr_prdata = cfg_ff.capacity[3];
         default:              csr_prdata = 32'd0;
      endcase
   end

   // Checks
   `ATB_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !in_valid_ff && !rsp_valid_ff, "pipeline not empty after reset")
   `ATB_ASSERT(a_in_held, clock, reset, in_valid_ff && !out_free |=> in_valid_ff && $stable(in_req_ff), "input register lost an item while stalled")
   `ATB_ASSERT(a_error_clean, clock, reset, rsp_valid_ff && rsp_data_ff.status != atb_pkg::STATUS_OK |-> rsp_data_ff.command_code == 8'd0 && rsp_data_ff.device_select == 8'd0, "error result carries taskfile values")
   `ATB_ASSERT(a_ext_opcode, clock, reset, rsp_valid_ff && rsp_data_ff.use_lba48 |-> rsp_data_ff.command_code == atb_pkg::OP_READ_EXT || rsp_data_ff.command_code == atb_pkg::OP_WRITE_EXT, "extended mode without extended opcode")

endmodule

`default_nettype wire

FILE: design/atb_xlate.sv
`default_nettype none

module atb_xlate (
   input  atb_pkg::req_payload_type  req_item,
   input  atb_pkg::cfg_type          cfg,
   output atb_pkg::rsp_payload_type  rsp_item
);

   logic [32:0]                                   end_sum;
   logic                                          over_range;
   logic                                          is_lba48;
   logic [atb_pkg::LBA28_W+atb_pkg::CHS_RECIP_W-1:0] recip_prod;
   logic [atb_pkg::CHS_QUOT_W-1:0]                chs_quot;
   logic [5:0]                                    chs_rem;
   logic [31:0]                                   lba;

   assign lba = req_item.block_addr;

   // Range check at 33 bits so the sum cannot wrap.
   assign end_sum    = {1'b0, lba} + {25'd0, req_item.sector_count};
   assign over_range = end_sum > {1'b0, cfg.capacity[req_item.drive_num]};
   assign is_lba48   = |lba[31:atb_pkg::LBA28_W];

   // CHS only applies below 2^28, so the quotient by 63 comes from a reciprocal
   // multiply. The remainder needs only six bits: lba - 63q equals lba + q mod 64.
   assign recip_prod = lba[atb_pkg::LBA28_W-1:0] * atb_pkg::CHS_RECIP;
   assign chs_quot   = recip_prod[atb_pkg::CHS_RECIP_SHIFT +: atb_pkg::CHS_QUOT_W];
   assign chs_rem    = lba[5:0] + chs_quot[5:0];

   always_comb begin
      rsp_item = '0;
      if (!cfg.present_mask[req_item.drive_num]) begin
         rsp_item.status = atb_pkg::STATUS_ABSENT;
      end else if (over_range) begin
         rsp_item.status = atb_pkg::STATUS_RANGE;
      end else begin
         rsp_item.status      = atb_pkg::STATUS_OK;
         rsp_item.channel_sel = req_item.drive_num[1];
         rsp_item.use_lba48   = is_lba48;
         rsp_item.count_out   = req_item.sector_count;
         priority if (is_lba48) begin
            rsp_item.device_select = atb_pkg::DEVSEL_LBA | {3'd0, req_item.drive_num[0], 4'd0};
            rsp_item.addr_byte0    = lba[7:0];
            rsp_item.addr_byte1    = lba[15:8];
            rsp_item.addr_byte2    = lba[23:16];
            rsp_item.addr_byte3    = lba[31:24];
         end else if (cfg.lba_capable_mask[req_item.drive_num]) begin
            rsp_item.device_select = atb_pkg::DEVSEL_LBA | {3'd0, req_item.drive_num[0], 4'd0}
                                     | {4'd0, lba[27:24]};
            rsp_item.addr_byte0    = lba[7:0];
            rsp_item.addr_byte1    = lba[15:8];
            rsp_item.addr_byte2    = lba[23:16];
         end else begin
            // Head is the quotient mod 16; the cylinder is the rest, kept to 16 bits.
            rsp_item.device_select = atb_pkg::DEVSEL_CHS | {3'd0, req_item.drive_num[0], 4'd0}
                                     | {4'd0, chs_quot[3:0]};
            rsp_item.addr_byte0    = {2'd0, chs_rem} + 8'd1;
            rsp_item.addr_byte1    = chs_quot[11:4];
            rsp_item.addr_byte2    = chs_quot[19:12];
         end
         unique case (atb_pkg::dir_type'(req_item.req_type))
            atb_pkg::DIR_READ: begin
               rsp_item.command_code = is_lba48 ? atb_pkg::OP_READ_EXT : atb_pkg::OP_READ;
               rsp_item.flush_code   = 8'd0;
            end
            atb_pkg::DIR_WRITE: begin
               rsp_item.command_code = is_lba48 ? atb_pkg::OP_WRITE_EXT : atb_pkg::OP_WRITE;
               rsp_item.flush_code   = is_lba48 ? atb_pkg::OP_FLUSH_EXT : atb_pkg::OP_FLUSH;
            end
            default: begin
               rsp_item.command_code = 8'd0;
               rsp_item.flush_code   = 8'd0;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

FILE: verif/atb_checker.sv
`default_nettype none

module atb_checker
   import atb_pkg::*;
(
   input  wire                          clock,
   input  wire                          reset,
   atb_req_if                           req,
   atb_rsp_if                           rsp,
   input  wire                          csr_psel,
   input  wire                          csr_penable,
   input  wire                          csr_pwrite,
   input  wire                          csr_pready,
   input  wire [CSR_ADDR_W-1:0]         csr_paddr,
   input  wire [31:0]                   csr_pwdata,
   output int unsigned                  fail_count,
   output int unsigned                  pending,
   output int unsigned                  chs_count,
   output int unsigned                  lba28_count,
   output int unsigned                  lba48_count,
   output int unsigned                  absent_count,
   output int unsigned                  range_count
);

   localparam logic [31:0] LBA48_BASE   = 32'h1000_0000;
   localparam logic [31:0] CHS_SECTORS  = 32'd63;
   localparam logic [31:0] CHS_HEADS    = 32'd16;
   localparam int unsigned MAX_REPORTS  = 40;

   cfg_type         drive_cfg;
   rsp_payload_type expected_taskfiles[$];
   int unsigned     errors;

   function automatic rsp_payload_type build_taskfile(req_payload_type r, cfg_type c);
      rsp_payload_type t;
      logic [32:0]     span_end;
      logic [31:0]     lba;
      logic [31:0]     cylinder;
      logic [7:0]      base;
      logic [3:0]      head;
      t = '0;
      lba = r.block_addr;
      span_end = {1'b0, lba} + {25'd0, r.sector_count};
      head = 4'h0;
      if (!c.present_mask[r.drive_num]) begin
         t.status = STATUS_ABSENT;
      end else if (span_end > {1'b0, c.capacity[r.drive_num]}) begin
         t.status = STATUS_RANGE;
      end else begin
         t.status = STATUS_OK;
         t.channel_sel = r.drive_num[1];
         t.count_out = r.sector_count;
         if (lba >= LBA48_BASE) begin
            t.use_lba48 = 1'b1;
            base = DEVSEL_LBA;
            {t.addr_byte3, t.addr_byte2, t.addr_byte1, t.addr_byte0} = lba;
         end else if (c.lba_capable_mask[r.drive_num]) begin
            base = DEVSEL_LBA;
            {t.addr_byte2, t.addr_byte1, t.addr_byte0} = lba[23:0];
            head = lba[27:24];
         end else begin
            // Geometry is 16 heads of 63 sectors; the cylinder keeps only 16 bits.
            cylinder = lba / (CHS_SECTORS * CHS_HEADS);
            base = DEVSEL_CHS;
            t.addr_byte0 = 8'(lba % CHS_SECTORS + 32'd1);
            t.addr_byte1 = cylinder[7:0];
            t.addr_byte2 = cylinder[15:8];
            head = 4'((lba / CHS_SECTORS) % CHS_HEADS);
         end
         t.device_select = base | {3'b000, r.drive_num[0], head};
         if (r.req_type == DIR_WRITE) begin
            t.command_code = t.use_lba48 ? OP_WRITE_EXT : OP_WRITE;
            t.flush_code = t.use_lba48 ? OP_FLUSH_EXT : OP_FLUSH;
         end else begin
            t.command_code = t.use_lba48 ? OP_READ_EXT : OP_READ;
         end
      end
      return t;
   endfunction

   task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         errors++;
         if (errors <= MAX_REPORTS) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
         end
      end
   endtask

   task automatic compare_taskfile(rsp_payload_type want, rsp_payload_type got);
      check_field("status", 32'(want.status), 32'(got.status));
      check_field("channel_sel", 32'(want.channel_sel), 32'(got.channel_sel));
      check_field("device_select", 32'(want.device_select), 32'(got.device_select));
      check_field("use_lba48", 32'(want.use_lba48), 32'(got.use_lba48));
      check_field("addr_byte0", 32'(want.addr_byte0), 32'(got.addr_byte0));
      check_field("addr_byte1", 32'(want.addr_byte1), 32'(got.addr_byte1));
      check_field("addr_byte2", 32'(want.addr_byte2), 32'(got.addr_byte2));
      check_field("addr_byte3", 32'(want.addr_byte3), 32'(got.addr_byte3));
      check_field("count_out", 32'(want.count_out), 32'(got.count_out));
      check_field("command_code", 32'(want.command_code), 32'(got.command_code));
      check_field("flush_code", 32'(want.flush_code), 32'(got.flush_code));
   endtask

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         drive_cfg = '0;
         expected_taskfiles.delete();
         errors = 0;
         chs_count <= 0;
         lba28_count <= 0;
         lba48_count <= 0;
         absent_count <= 0;
         range_count <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr[4:2]))
               REG_PRESENT: drive_cfg.present_mask = csr_pwdata[3:0];
               REG_LBA_CAP: drive_cfg.lba_capable_mask = csr_pwdata[3:0];
               REG_CAP0, REG_CAP1, REG_CAP2, REG_CAP3: begin
                  drive_cfg.capacity[2'(csr_paddr[4:2] - 3'(REG_CAP0))] = csr_pwdata;
               end
               default: ;
            endcase
         end
         // Results always trail their requests, so compare first.
         if (rsp.valid && rsp.ready) begin
            if (expected_taskfiles.size() == 0) begin
               errors++;
               if (errors <= MAX_REPORTS) begin
                  $display("%0t: result item with nothing expected, got 0x%0h",
                           $time, rsp.data);
               end
            end else begin
               want = expected_taskfiles.pop_front();
               compare_taskfile(want, rsp.data);
               if (want.status == STATUS_ABSENT) absent_count <= absent_count + 1;
               else if (want.status == STATUS_RANGE) range_count <= range_count + 1;
               else if (want.use_lba48) lba48_count <= lba48_count + 1;
               else if (want.device_select[7:5] == DEVSEL_LBA[7:5]) begin
                  lba28_count <= lba28_count + 1;
               end else chs_count <= chs_count + 1;
            end
         end
         if (req.valid && req.ready) begin
            expected_taskfiles.push_back(build_taskfile(req.data, drive_cfg));
         end
      end
      pending <= expected_taskfiles.size();
      fail_count <= errors;
   end

endmodule

`default_nettype wire

FILE: verif/tb.sv
`default_nettype none

module tb;
   import atb_pkg::*;

   localparam int unsigned IDLE_LIMIT        = 2000;
   localparam int unsigned HOLD_OFF_CYCLES   = 300;
   localparam int unsigned ITEMS_PER_SETTING = 190;
   localparam int unsigned SETTLE_CYCLES     = 4;

   typedef enum int unsigned {
      SET_ALL_CHS,
      SET_ALL_LBA,
      SET_RANDOM,
      SET_SMALL_CAPS,
      SET_NONE_PRESENT,
      SET_NEAR_LBA48,
      SET_COUNT
   } setting_type;

   typedef enum int unsigned {
      RX_STEADY,
      RX_COIN,
      RX_SPARSE,
      RX_RARE_STALL
   } rx_mode_type;

   typedef enum int unsigned {
      AIM_ANY,
      AIM_LOW_LBA,
      AIM_CAP_EDGE,
      AIM_LBA48_EDGE,
      AIM_FIRST_TRACKS
   } aim_type;

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic csr_pready;

   logic        hold_off_req;
   logic [31:0] cap_shadow[4];
   int unsigned burst_left;
   int unsigned request_count;
   int unsigned quiet_cycles;

   int unsigned fail_count;
   int unsigned pending;
   int unsigned chs_count;
   int unsigned lba28_count;
   int unsigned lba48_count;
   int unsigned absent_count;
   int unsigned range_count;

   atb_req_if req_bus();
   atb_rsp_if rsp_bus();

   ata_taskfile_command_builder i_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   atb_checker i_checker (
      .clock        (clock),
      .reset        (reset),
      .req          (req_bus),
      .rsp          (rsp_bus),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_pready   (csr_pready),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .fail_count   (fail_count),
      .pending      (pending),
      .chs_count    (chs_count),
      .lba28_count  (lba28_count),
      .lba48_count  (lba48_count),
      .absent_count (absent_count),
      .range_count  (range_count)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("Timeout: no item moved for %0d cycles, %0d results outstanding",
                  quiet_cycles, pending);
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // The receiver changes its stall pattern every so often and honors one long
   // hold-off on request, during which the block has to back-pressure its input.
   initial begin : receiver
      int unsigned tick;
      rx_mode_type mode;
      tick = 0;
      mode = RX_STEADY;
      rsp_bus.ready = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end
         if (tick % 80 == 0) mode = rx_mode_type'($urandom_range(RX_STEADY, RX_RARE_STALL));
         case (mode)
            RX_STEADY:   rsp_bus.ready <= 1'b1;
            RX_COIN:     rsp_bus.ready <= 1'($urandom_range(0, 1));
            RX_SPARSE:   rsp_bus.ready <= (tick % 4 == 0);
            default:     rsp_bus.ready <= ($urandom_range(0, 9) != 0);
         endcase
         tick++;
      end
   end

   task automatic write_register(reg_index_type idx, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
   endtask

   task automatic write_config(logic [3:0] present, logic [3:0] lba_cap, logic [31:0] cap0,
                               logic [31:0] cap1, logic [31:0] cap2, logic [31:0] cap3);
      write_register(REG_PRESENT, {28'd0, present});
      write_register(REG_LBA_CAP, {28'd0, lba_cap});
      write_register(REG_CAP0, cap0);
      write_register(REG_CAP1, cap1);
      write_register(REG_CAP2, cap2);
      write_register(REG_CAP3, cap3);
      cap_shadow[0] = cap0;
      cap_shadow[1] = cap1;
      cap_shadow[2] = cap2;
      cap_shadow[3] = cap3;
   endtask

   task automatic send_item(req_payload_type item);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 16);
      end
      req_bus.valid <= 1'b1;
      req_bus.data <= item;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      burst_left--;
      request_count++;
   endtask

   task automatic send_request(dir_type dir, logic [1:0] drive, logic [31:0] addr,
                               logic [7:0] count);
      req_payload_type item;
      item.req_type = dir;
      item.drive_num = drive;
      item.block_addr = addr;
      item.sector_count = count;
      send_item(item);
   endtask

   // Stops offering items and waits until every result has come back.
   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending != 0);
      @(negedge clock);
   endtask

   function automatic req_payload_type random_request();
      req_payload_type item;
      aim_type aim;
      int unsigned pick;
      item.req_type = 1'($urandom_range(0, 1));
      item.drive_num = 2'($urandom_range(0, 3));
      pick = $urandom_range(0, 9);
      item.sector_count = (pick == 0) ? 8'd0 : (pick == 1) ? 8'hFF : 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      aim = (pick < 30) ? AIM_ANY : (pick < 55) ? AIM_LOW_LBA : (pick < 80) ? AIM_CAP_EDGE :
            (pick < 90) ? AIM_LBA48_EDGE : AIM_FIRST_TRACKS;
      case (aim)
         AIM_ANY:        item.block_addr = $urandom();
         AIM_LOW_LBA:    item.block_addr = {4'h0, 28'($urandom())};
         // Lands the end of the span just below, on or just past the capacity.
         AIM_CAP_EDGE:   item.block_addr = cap_shadow[item.drive_num] - 32'(item.sector_count)
                                           + 32'($urandom_range(0, 4)) - 32'd2;
         AIM_LBA48_EDGE: item.block_addr = 32'h1000_0000 + 32'($urandom_range(0, 6)) - 32'd3;
         default:        item.block_addr = 32'($urandom_range(0, 2100));
      endcase
      return item;
   endfunction

   initial begin : stimulus
      setting_type setting;
      reset = 1'b1;
      hold_off_req = 1'b0;
      burst_left = 0;
      request_count = 0;
      quiet_cycles = 0;
      req_bus.valid = 1'b0;
      req_bus.data = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      for (int d = 0; d < 4; d++) cap_shadow[d] = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Out of reset no drive is present.
      send_request(DIR_READ, 2'd0, 32'd0, 8'd1);
      send_request(DIR_WRITE, 2'd3, 32'hFFFF_FFFF, 8'hFF);
      wait_for_results();

      // Drives 0 and 2 take LBA, drives 1 and 3 use CHS below the LBA48 boundary.
      write_config(4'hF, 4'b0101, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1000_0000, 32'd5000);
      send_request(DIR_READ, 2'd0, 32'd0, 8'd0);
      send_request(DIR_WRITE, 2'd0, 32'h0FFF_FFFF, 8'hFF);
      send_request(DIR_READ, 2'd0, 32'h1000_0000, 8'd1);
      send_request(DIR_WRITE, 2'd1, 32'hFFFF_FFFF, 8'd0);
      send_request(DIR_WRITE, 2'd1, 32'hFFFF_FFFF, 8'd1);
      send_request(DIR_READ, 2'd1, 32'hFFFF_FF00, 8'hFF);
      send_request(DIR_READ, 2'd1, 32'hFFFF_FF01, 8'hFF);
      send_request(DIR_READ, 2'd1, 32'd0, 8'd1);
      send_request(DIR_WRITE, 2'd1, 32'd62, 8'd2);
      send_request(DIR_WRITE, 2'd1, 32'd63, 8'd2);
      send_request(DIR_READ, 2'd1, 32'd1008, 8'd2);
      send_request(DIR_WRITE, 2'd1, 32'h0FFF_FFFF, 8'd8);
      send_request(DIR_READ, 2'd1, 32'd66060288, 8'd3);
      send_request(DIR_WRITE, 2'd3, 32'd4990, 8'd10);
      send_request(DIR_WRITE, 2'd3, 32'd4991, 8'd10);
      send_request(DIR_READ, 2'd2, 32'h0FFF_FFF0, 8'h10);
      send_request(DIR_WRITE, 2'd2, 32'h1000_0000, 8'd0);
      send_request(DIR_WRITE, 2'd2, 32'h1000_0000, 8'd1);

      for (int p = 0; p < SET_COUNT; p++) begin
         setting = setting_type'(p);
         wait_for_results();
         case (setting)
            SET_ALL_CHS:
               write_config(4'hF, 4'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            32'hFFFF_FFFF);
            SET_ALL_LBA:
               write_config(4'hF, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            32'hFFFF_FFFF);
            SET_RANDOM:
               write_config(4'($urandom()), 4'($urandom()), $urandom(), $urandom(),
                            $urandom(), $urandom());
            SET_SMALL_CAPS:
               write_config(4'hF, 4'($urandom()), 32'($urandom_range(0, 20000)),
                            32'($urandom_range(0, 20000)), 32'd0,
                            32'($urandom_range(0, 20000)));
            SET_NONE_PRESENT:
               write_config(4'h0, 4'hF, 32'd0, 32'd0, 32'd0, 32'd0);
            default:
               write_config(4'($urandom()), 4'($urandom()),
                            32'h1000_0000 - 32'd300 + 32'($urandom_range(0, 600)),
                            32'h1000_0000 + 32'($urandom_range(0, 300)),
                            32'hFFFF_FFFF, $urandom());
         endcase
         if (setting == SET_RANDOM) hold_off_req = 1'b1;
         for (int k = 0; k < ITEMS_PER_SETTING; k++) begin
            if (setting == SET_ALL_LBA && k == ITEMS_PER_SETTING / 2) wait_for_results();
            send_item(random_request());
         end
      end

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Run covered %0d requests over %0d register settings with bursty input",
               request_count, SET_COUNT + 2);
      $display("and stalled output: %0d CHS, %0d LBA28, %0d LBA48, %0d absent, %0d range.",
               chs_count, lba28_count, lba48_count, absent_count, range_count);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+design
design/atb_pkg.sv
design/atb_if.sv
design/atb_xlate.sv
design/ata_taskfile_command_builder.sv
verif/atb_checker.sv
verif/tb.sv
